@@ hw/rtl/three_level_fifo_priority_queue_macros.svh @@
// Assertion macros for the ticket priority queue.
`ifndef THREE_LEVEL_FIFO_PRIORITY_QUEUE_MACROS_SVH
`define THREE_LEVEL_FIFO_PRIORITY_QUEUE_MACROS_SVH
// Implication checked on every edge outside reset.
`define TFPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define TFPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/tfpq_pkg.sv @@
// Types and codes shared by the ticket priority queue.
package tfpq_pkg;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SETPRI = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;
  localparam logic [1:0] CMD_LOOKUP = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_LEVEL = 3'd4;

  localparam logic [1:0] LVL_LOW = 2'd1;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] ticket_id;
    logic [1:0]         new_level;
  } tfpq_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] found_id;
    logic [1:0]         found_level;
    logic [31:0]        found_stamp;
    logic [4:0]         occupancy;
  } tfpq_out_t;
endpackage

@@ hw/rtl/tfpq_cmd_fifo.sv @@
// Front part: two-entry request queue between the port and the cell array.
module tfpq_cmd_fifo
  import tfpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tfpq_in_t in_data,
  output logic     q_valid,
  input  logic     q_take,
  output tfpq_in_t q_data
);
  tfpq_in_t   mem_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= in_data;
  end
endmodule

@@ hw/rtl/tfpq_cells.sv @@
// Back part: ordered row of entry cells with search, insert and removal.
module tfpq_cells
  import tfpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_take,
  input  tfpq_in_t  q_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tfpq_out_t out_data
);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {S_EVAL = 2'b01, S_APPLY = 2'b10} state_t;

  state_t              state_r, state_nxt;
  logic [ID_BITS-1:0]  id_r  [QUEUE_DEPTH];
  logic [1:0]          lvl_r [QUEUE_DEPTH];
  logic [31:0]         stp_r [QUEUE_DEPTH];
  logic [CW-1:0]       cnt_r;
  logic [31:0]         ctr_r;
  logic                ov_r;
  tfpq_out_t           od_r;

  // Decision registers captured in S_EVAL.
  logic                do_rm_r, do_pl_r;
  logic [PW-1:0]       rmp_r;
  logic [ID_BITS-1:0]  nid_r;
  logic [1:0]          nlv_r;
  logic [CW-1:0]       after_rm_r;

  logic [QUEUE_DEPTH-1:0] hit, valid_v;
  logic                found;
  logic [PW-1:0]       fpos;
  logic [ID_BITS-1:0]  key;

  assign key = ID_BITS'($unsigned(q_data.ticket_id));

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      valid_v[i] = (CW'(i) < cnt_r);
      hit[i] = valid_v[i] && (id_r[i] == key);
    end
    found = |hit;
    fpos  = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) fpos = PW'(i);
    end
  end

  // S_APPLY: row after removal, then after placement.
  logic [ID_BITS-1:0] aid [QUEUE_DEPTH];
  logic [1:0]         alv [QUEUE_DEPTH];
  logic [31:0]        ast [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] aval, below;
  logic [ID_BITS-1:0] nid_v [QUEUE_DEPTH];
  logic [1:0]         nlv_v [QUEUE_DEPTH];
  logic [31:0]        nst_v [QUEUE_DEPTH];

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_rm_r && PW'(i) >= rmp_r && i + 1 < QUEUE_DEPTH) begin
        aid[i] = id_r[(i + 1) % QUEUE_DEPTH];
        alv[i] = lvl_r[(i + 1) % QUEUE_DEPTH];
        ast[i] = stp_r[(i + 1) % QUEUE_DEPTH];
      end else begin
        aid[i] = id_r[i]; alv[i] = lvl_r[i]; ast[i] = stp_r[i];
      end
      aval[i]  = (CW'(i) < after_rm_r);
      below[i] = !aval[i] || (alv[i] < nlv_r);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (!do_pl_r || !below[i]) begin
        nid_v[i] = aid[i]; nlv_v[i] = alv[i]; nst_v[i] = ast[i];
      end else if (i == 0 || !below[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]) begin
        nid_v[i] = nid_r; nlv_v[i] = nlv_r; nst_v[i] = ctr_r;
      end else begin
        nid_v[i] = aid[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
        nlv_v[i] = alv[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
        nst_v[i] = ast[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
      end
    end
  end

  logic start;
  assign start    = (state_r == S_EVAL) && q_valid && (!ov_r || !out_stall);
  assign q_take   = start;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  tfpq_out_t     res;
  logic          rm, pl;
  logic [CW-1:0] arm, cfin;

  always_comb begin
    res = '0; rm = 1'b0; pl = 1'b0;
    arm = cnt_r;
    case (q_data.command)
      CMD_INSERT: begin
        if (cnt_r == CW'(QUEUE_DEPTH)) res.status = ST_FULL;
        else pl = 1'b1;
      end
      default: begin
        if (cnt_r == '0) begin
          res.status = ST_EMPTY;
        end else if (q_data.command == CMD_POP) begin
          res.found_id    = 32'(id_r[0]);
          res.found_level = lvl_r[0];
          res.found_stamp = stp_r[0];
          rm = 1'b1;
        end else if (!found) begin
          res.status = ST_NOT_FOUND;
        end else if (q_data.command == CMD_LOOKUP) begin
          res.found_id    = 32'(id_r[fpos]);
          res.found_level = lvl_r[fpos];
          res.found_stamp = stp_r[fpos];
        end else if (q_data.new_level == 2'd0) begin
          res.status = ST_BAD_LEVEL;
        end else begin
          res.found_id    = 32'(id_r[fpos]);
          res.found_level = q_data.new_level;
          res.found_stamp = ctr_r;
          rm = 1'b1; pl = 1'b1;
        end
      end
    endcase
    if (rm) arm = cnt_r - CW'(1);
    cfin = arm + CW'(pl);
    res.occupancy = 5'(cfin);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_EVAL:  if (start) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_EVAL;
      default: state_nxt = S_EVAL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EVAL; cnt_r <= '0; ctr_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      if (state_r == S_APPLY) begin
        if (do_pl_r) begin
          ctr_r <= ctr_r + 32'd1;
          cnt_r <= after_rm_r + CW'(1);
        end else begin
          cnt_r <= after_rm_r;
        end
      end
    end
    if (start) begin
      od_r <= res;
      do_rm_r <= rm; do_pl_r <= pl;
      rmp_r <= (q_data.command == CMD_POP) ? '0 : fpos;
      nid_r <= (q_data.command == CMD_INSERT) ? key : id_r[fpos];
      nlv_r <= (q_data.command == CMD_INSERT) ? LVL_LOW : q_data.new_level;
      after_rm_r <= arm;
    end
    if (state_r == S_APPLY) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        id_r[i] <= nid_v[i]; lvl_r[i] <= nlv_v[i]; stp_r[i] <= nst_v[i];
      end
    end
  end
endmodule

@@ hw/rtl/three_level_fifo_priority_queue.sv @@
// Ticket priority queue: three levels, oldest first within a level.
// Each request passes the cell row in S_EVAL, to search and decide, then in
// S_APPLY, to shift the row for removal and placement; the row takes no new
// request until the last has left S_APPLY. A two-entry request queue in front
// and a result register behind let either port stall on its own. Results come
// in request order, one per request. No clearing pass after reset.
module three_level_fifo_priority_queue
  import tfpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tfpq_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tfpq_out_t out_data
);
  `include "three_level_fifo_priority_queue_macros.svh"

  logic     q_valid, q_take;
  tfpq_in_t q_data;

  tfpq_cmd_fifo u_fifo (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_take, .q_data
  );

  tfpq_cells #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_cells (
    .clk, .rst_n, .q_valid, .q_take, .q_data, .out_valid, .out_stall, .out_data
  );

  `TFPQ_ASSERT_IMP(a_take_ok, q_take, q_valid && !(out_valid && out_stall), "take while blocked")
  `TFPQ_ASSERT_NEXT(a_take_out, q_take, out_valid, "result missing after take")
  `TFPQ_ASSERT_IMP(a_occ, out_valid, out_data.occupancy <= 5'(QUEUE_DEPTH), "occupancy too big")
endmodule

@@ dv/three_level_fifo_priority_queue_tb.sv @@
// Self-checking testbench for the three-level ticket priority queue.
module three_level_fifo_priority_queue_tb;
  import tfpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int RANDOM_REQS = 1880;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  tfpq_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  tfpq_out_t out_data;

  three_level_fifo_priority_queue u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Shadow of the queue, kept in service order.
  logic [31:0] q_id[DEPTH];
  logic [1:0]  q_lvl[DEPTH];
  logic [31:0] q_stamp[DEPTH];
  int          q_count;
  logic [31:0] stamp_ctr;
  tfpq_out_t   pending_results[$];
  int          errors;
  bit          stim_done;
  bit          hold_off;
  int          cycles;
  logic [31:0] recent_ids[8];

  function automatic void drop_at(int p);
    for (int i = p; i + 1 < q_count; i++) begin
      q_id[i] = q_id[i+1]; q_lvl[i] = q_lvl[i+1]; q_stamp[i] = q_stamp[i+1];
    end
    q_count--;
  endfunction

  function automatic void place_entry(logic [31:0] id, logic [1:0] lvl, logic [31:0] st);
    int pos;
    pos = q_count;
    for (int i = 0; i < q_count; i++) begin
      if (q_lvl[i] < lvl) begin
        pos = i;
        break;
      end
    end
    for (int i = q_count; i > pos; i--) begin
      q_id[i] = q_id[i-1]; q_lvl[i] = q_lvl[i-1]; q_stamp[i] = q_stamp[i-1];
    end
    q_id[pos] = id; q_lvl[pos] = lvl; q_stamp[pos] = st;
    q_count++;
  endfunction

  function automatic tfpq_out_t queue_response(tfpq_in_t req);
    tfpq_out_t r;
    int p;
    r = '0;
    r.status = ST_OK;
    if (req.command == CMD_INSERT) begin
      if (q_count >= DEPTH) r.status = ST_FULL;
      else begin
        place_entry(req.ticket_id, LVL_LOW, stamp_ctr);
        stamp_ctr++;
      end
    end else if (q_count == 0) begin
      r.status = ST_EMPTY;
    end else if (req.command == CMD_POP) begin
      r.found_id = q_id[0]; r.found_level = q_lvl[0]; r.found_stamp = q_stamp[0];
      drop_at(0);
    end else begin
      p = q_count;
      for (int i = 0; i < q_count; i++) begin
        if (q_id[i] == req.ticket_id) begin
          p = i;
          break;
        end
      end
      if (p >= q_count) r.status = ST_NOT_FOUND;
      else if (req.command == CMD_LOOKUP) begin
        r.found_id = q_id[p]; r.found_level = q_lvl[p]; r.found_stamp = q_stamp[p];
      end else if (req.new_level == 2'd0) begin
        r.status = ST_BAD_LEVEL;
      end else begin
        r.found_id = q_id[p];
        drop_at(p);
        place_entry(r.found_id, req.new_level, stamp_ctr);
        r.found_level = req.new_level;
        r.found_stamp = stamp_ctr;
        stamp_ctr++;
      end
    end
    r.occupancy = 5'(q_count);
    return r;
  endfunction

  // Directed table; a row with has_exp set carries a typed-in result.
  typedef struct {
    tfpq_in_t  req;
    bit        has_exp;
    tfpq_out_t exp;
  } step_row_t;

  step_row_t directed[$];

  function automatic step_row_t mk(logic [1:0] c, logic [31:0] id, logic [1:0] l,
                                   bit he = 0, tfpq_out_t e = '0);
    step_row_t s;
    s.req = '{command: c, ticket_id: id, new_level: l};
    s.has_exp = he;
    s.exp = e;
    return s;
  endfunction

  // Keep valid high between back-to-back requests; drop it only across a gap.
  task automatic send_request(tfpq_in_t req, bit has_exp, tfpq_out_t exp);
    tfpq_out_t pred;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 4) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = queue_response(req);
    if (has_exp && pred !== exp) begin
      $display("%0t predictor disagrees with table: exp %p got %p", $time, exp, pred);
      errors++;
    end
    pending_results.push_back(has_exp ? exp : pred);
  endtask

  function automatic logic [31:0] pick_id();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return recent_ids[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin
    tfpq_in_t req;
    int k;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    errors = 0; stim_done = 0; hold_off = 0; cycles = 0;
    q_count = 0; stamp_ctr = '0;
    for (int i = 0; i < DEPTH; i++) begin
      q_id[i] = '0; q_lvl[i] = '0; q_stamp[i] = '0;
    end
    for (int i = 0; i < 8; i++) recent_ids[i] = $urandom;
    recent_ids[0] = 32'h8000_0000; recent_ids[1] = 32'h7fff_ffff;
    recent_ids[2] = 32'hffff_ffff; recent_ids[3] = 32'h0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    directed.push_back(mk(CMD_POP, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 0}));
    directed.push_back(mk(CMD_LOOKUP, 5, 0, 1, '{ST_EMPTY, 0, 0, 0, 0}));
    directed.push_back(mk(CMD_SETPRI, 5, 3, 1, '{ST_EMPTY, 0, 0, 0, 0}));
    directed.push_back(mk(CMD_INSERT, 32'h8000_0000, 0, 1, '{ST_OK, 0, 0, 0, 1}));
    directed.push_back(mk(CMD_INSERT, 32'h7fff_ffff, 3));
    directed.push_back(mk(CMD_INSERT, 32'hffff_ffff, 0));
    directed.push_back(mk(CMD_INSERT, 32'h7fff_ffff, 0));
    directed.push_back(mk(CMD_LOOKUP, 32'h1234, 0, 1, '{ST_NOT_FOUND, 0, 0, 0, 4}));
    directed.push_back(mk(CMD_SETPRI, 32'hffff_ffff, 0, 1, '{ST_BAD_LEVEL, 0, 0, 0, 4}));
    directed.push_back(mk(CMD_SETPRI, 32'hffff_ffff, 3));
    directed.push_back(mk(CMD_SETPRI, 32'h7fff_ffff, 2));
    directed.push_back(mk(CMD_SETPRI, 32'h8000_0000, 1));
    directed.push_back(mk(CMD_LOOKUP, 32'h7fff_ffff, 0));
    for (int i = 0; i < 13; i++) directed.push_back(mk(CMD_INSERT, i, 0));
    directed.push_back(mk(CMD_INSERT, 32'h55, 0, 1, '{ST_FULL, 0, 0, 0, 16}));
    foreach (directed[i]) send_request(directed[i].req, directed[i].has_exp, directed[i].exp);
    for (int i = 0; i < 16; i++) send_request('{CMD_POP, $urandom, 2'($urandom)}, 0, '0);

    // Long receiver hold-off while the sender keeps the block busy.
    hold_off = 1;
    for (int i = 0; i < 24; i++)
      send_request('{CMD_INSERT, pick_id(), 2'($urandom)}, 0, '0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      req.ticket_id = pick_id();
      req.new_level = 2'($urandom);
      k = $urandom_range(0, 99);
      if (k < 30) req.command = CMD_INSERT;
      else if (k < 55) req.command = CMD_SETPRI;
      else if (k < 78) req.command = CMD_POP;
      else req.command = CMD_LOOKUP;
      if (req.command == CMD_INSERT && $urandom_range(0, 3) == 0)
        recent_ids[$urandom_range(0, 7)] = req.ticket_id;
      send_request(req, 0, '0);
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  always @(posedge clk) begin
    int wait_n;
    if (hold_off) begin
      out_stall <= 1'b1;
      repeat (150) @(posedge clk);
      hold_off = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    tfpq_out_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: got %p", $time, out_data);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (out_data.status !== exp.status || out_data.found_id !== exp.found_id ||
            out_data.found_level !== exp.found_level ||
            out_data.found_stamp !== exp.found_stamp ||
            out_data.occupancy !== exp.occupancy) begin
          $display("%0t mismatch: exp %p got %p", $time, exp, out_data);
          errors++;
        end
      end
    end
  end

  initial begin
    @(posedge rst_n);
    wait (stim_done && pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end
endmodule

@@ three_level_fifo_priority_queue.f @@
+incdir+hw/rtl
hw/rtl/tfpq_pkg.sv
hw/rtl/tfpq_cmd_fifo.sv
hw/rtl/tfpq_cells.sv
hw/rtl/three_level_fifo_priority_queue.sv
dv/three_level_fifo_priority_queue_tb.sv
